// ----- rtl/cvs_pkg.sv -----
// ----------------------------------------------------------------------------
// cvs_pkg: shared constants and types
// common widths and the packed vector type of the capsule squash pipeline
// ----------------------------------------------------------------------------
package cvs_pkg;

	localparam int VECTOR_DIM   = 8;
	localparam int DATA_W       = 32;
	localparam int NORM_W       = 31;
	localparam int FRAC_BITS_DEF = 16;

	typedef logic [VECTOR_DIM-1:0][DATA_W-1:0] vec_t;
	typedef logic [VECTOR_DIM-1:0]             sign_t;

endpackage

// ----- rtl/cvs_norm.sv -----
// ----------------------------------------------------------------------------
// cvs_norm: squared norm stages
// magnitude, truncated squares, two-level sum and saturation in four stages
// ----------------------------------------------------------------------------
module cvs_norm #(
	parameter int FRAC_BITS = cvs_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      en,
	input  cvs_pkg::vec_t             comp,
	output cvs_pkg::vec_t             mag,
	output cvs_pkg::sign_t            neg,
	output logic [cvs_pkg::NORM_W-1:0] norm
);

	localparam int SQW  = 2 * cvs_pkg::DATA_W - FRAC_BITS;
	localparam int SUMW = SQW + 3;
	localparam int HALF = cvs_pkg::VECTOR_DIM / 2;

	cvs_pkg::vec_t  mag_s1, mag_s2, mag_s3, mag_s4;
	cvs_pkg::sign_t neg_s1, neg_s2, neg_s3, neg_s4;
	logic [SQW-1:0]  sq_s2   [cvs_pkg::VECTOR_DIM];
	logic [SUMW-1:0] pair_s3 [HALF];
	logic [cvs_pkg::NORM_W-1:0] norm_s4;
	logic [SUMW-1:0] total;

	always_comb begin
		total = '0;
		for (int i = 0; i < HALF; i++) begin
			total = total + pair_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < cvs_pkg::VECTOR_DIM; i++) begin
				neg_s1[i] <= comp[i][cvs_pkg::DATA_W-1];
				mag_s1[i] <= comp[i][cvs_pkg::DATA_W-1] ? (~comp[i] + 1'b1) : comp[i];
				sq_s2[i]  <= SQW'(({32'd0, mag_s1[i]} * {32'd0, mag_s1[i]}) >> FRAC_BITS);
			end
			for (int i = 0; i < HALF; i++) begin
				pair_s3[i] <= SUMW'(sq_s2[2*i]) + SUMW'(sq_s2[2*i+1]);
			end
			// saturate at the largest positive q format value
			norm_s4 <= (total > SUMW'({cvs_pkg::NORM_W{1'b1}})) ?
				{cvs_pkg::NORM_W{1'b1}} : total[cvs_pkg::NORM_W-1:0];
			mag_s2 <= mag_s1; mag_s3 <= mag_s2; mag_s4 <= mag_s3;
			neg_s2 <= neg_s1; neg_s3 <= neg_s2; neg_s4 <= neg_s3;
		end
	end

	assign mag  = mag_s4;
	assign neg  = neg_s4;
	assign norm = norm_s4;

endmodule

// ----- rtl/cvs_div.sv -----
// ----------------------------------------------------------------------------
// cvs_div: pipelined restoring divider
// one quotient bit per stage, the numerator's low part is all zeros
// ----------------------------------------------------------------------------
module cvs_div #(
	parameter int DW = 32,
	parameter int QW = 16
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] rem_in,
	input  logic [DW-1:0] den_in,
	output logic [QW-1:0] quo
);

	logic [DW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] rem_p, den_p;
		logic [QW-1:0] quo_p;
		logic [DW:0]   sh;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_p = rem_in;
			assign den_p = den_in;
			assign quo_p = '0;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign den_p = den_s[k-1];
			assign quo_p = quo_s[k-1];
		end

		assign sh = {rem_p, 1'b0};
		assign ge = (sh >= {1'b0, den_p});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(sh - {1'b0, den_p}) : sh[DW-1:0];
				den_s[k] <= den_p;
				quo_s[k] <= {quo_p[QW-2:0], ge};
			end
		end
	end

	assign quo = quo_s[QW-1];

endmodule

// ----- rtl/cvs_sqrt.sv -----
// ----------------------------------------------------------------------------
// cvs_sqrt: pipelined integer square root
// two radicand bits and one root bit per stage, truncated result
// ----------------------------------------------------------------------------
module cvs_sqrt #(
	parameter int SQ = 24
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*SQ-1:0] rad_in,
	output logic [SQ-1:0]   root
);

	localparam int RW = SQ + 2;

	logic [2*SQ-1:0] x_s    [SQ];
	logic [RW-1:0]   rem_s  [SQ];
	logic [SQ-1:0]   root_s [SQ];

	for (genvar k = 0; k < SQ; k++) begin : g_stage
		logic [2*SQ-1:0] x_p;
		logic [RW-1:0]   rem_p;
		logic [SQ-1:0]   root_p;
		logic [RW+1:0]   cur, trial;
		logic            ge;

		if (k == 0) begin : g_first
			assign x_p    = rad_in;
			assign rem_p  = '0;
			assign root_p = '0;
		end else begin : g_next
			assign x_p    = x_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
		end

		assign cur   = {rem_p, x_p[2*SQ-1 -: 2]};
		assign trial = (RW+2)'({root_p, 2'b01});
		assign ge    = (cur >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k]    <= x_p << 2;
				rem_s[k]  <= ge ? RW'(cur - trial) : RW'(cur);
				root_s[k] <= {root_p[SQ-2:0], ge};
			end
		end
	end

	assign root = root_s[SQ-1];

endmodule

// ----- rtl/capsule_vector_squash.sv -----
// ----------------------------------------------------------------------------
// capsule_vector_squash: capsule squash activation
// scales an 8-element fixed-point vector by n/(1+n)/sqrt(n)
// ----------------------------------------------------------------------------
// One capsule vector enters per clock and one squashed vector leaves per
// clock, fully pipelined, while the output is not stalled. With
// SQ = (32 + FRAC_BITS) / 2, the stages are four norm stages, one stage per
// root bit of the square root of n << FRAC_BITS (the n/(1+n) divider runs
// beside it), one stage per quotient bit of the scale divider, then a
// multiply stage and the output register. The whole pipeline holds when the
// output transaction is stalled; no data is lost.
// A zero vector gives a zero result, and a norm above 2^31 - 1 saturates.
module capsule_vector_squash #(
	parameter int FRAC_BITS = cvs_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [255:0] s_tdata,   // comp_0 .. comp_7, 32 bits each from bit 0
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [255:0] m_tdata    // squashed_0 .. squashed_7, 32 bits each from bit 0
);

	localparam int SQ  = (32 + FRAC_BITS) / 2;     // root bits of n << FRAC_BITS
	localparam int QD  = SQ - FRAC_BITS;           // align n/(1+n) with the root
	localparam int MD  = SQ + FRAC_BITS;           // magnitude delay after the norm
	localparam int LAT = 4 + SQ + FRAC_BITS + 2;
	localparam int DW  = cvs_pkg::DATA_W;
	localparam int PW  = DW + FRAC_BITS;

	// global pipeline advance: the output register is free or being taken
	logic en;
	logic [LAT-1:0] vld_q;

	assign en       = !vld_q[LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// squared norm
	cvs_pkg::vec_t  comp, mag;
	cvs_pkg::sign_t neg;
	logic [cvs_pkg::NORM_W-1:0] norm;

	assign comp = s_tdata;

	cvs_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
		.clk  (clk),
		.en   (en),
		.comp (comp),
		.mag  (mag),
		.neg  (neg),
		.norm (norm)
	);

	// n/(1+n) in q format, beside the root of n
	logic [FRAC_BITS-1:0] ratio;
	logic [SQ-1:0]        root;

	cvs_div #(.DW(DW), .QW(FRAC_BITS)) u_ratio (
		.clk    (clk),
		.en     (en),
		.rem_in (DW'(norm)),
		.den_in (DW'(norm) + (DW'(1) << FRAC_BITS)),
		.quo    (ratio)
	);

	cvs_sqrt #(.SQ(SQ)) u_sqrt (
		.clk    (clk),
		.en     (en),
		.rad_in ((2*SQ)'(norm) << FRAC_BITS),
		.root   (root)
	);

	logic [FRAC_BITS-1:0] ratio_d [QD];

	always_ff @(posedge clk) begin
		if (en) begin
			ratio_d[0] <= ratio;
			for (int i = 1; i < QD; i++) begin
				ratio_d[i] <= ratio_d[i-1];
			end
		end
	end

	// scale = ratio / root, forced to zero for a zero norm
	logic [FRAC_BITS-1:0] scale;
	logic                 zero_d [FRAC_BITS];

	cvs_div #(.DW(SQ), .QW(FRAC_BITS)) u_scale (
		.clk    (clk),
		.en     (en),
		.rem_in (SQ'(ratio_d[QD-1])),
		.den_in (root),
		.quo    (scale)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			zero_d[0] <= (root == '0);
			for (int i = 1; i < FRAC_BITS; i++) begin
				zero_d[i] <= zero_d[i-1];
			end
		end
	end

	// magnitudes and signs wait for the scale
	cvs_pkg::vec_t  mag_d [MD];
	cvs_pkg::sign_t neg_d [MD];

	always_ff @(posedge clk) begin
		if (en) begin
			mag_d[0] <= mag;
			neg_d[0] <= neg;
			for (int i = 1; i < MD; i++) begin
				mag_d[i] <= mag_d[i-1];
				neg_d[i] <= neg_d[i-1];
			end
		end
	end

	// multiply stage, then floor shift and sign restore
	logic [PW-1:0]  prod_s1 [cvs_pkg::VECTOR_DIM];
	cvs_pkg::sign_t neg_s1;
	cvs_pkg::vec_t  res_s2;
	logic [FRAC_BITS-1:0] scale_eff;

	assign scale_eff = zero_d[FRAC_BITS-1] ? '0 : scale;

	always_ff @(posedge clk) begin
		logic [PW:0] t;
		logic [DW:0] r;
		if (en) begin
			neg_s1 <= neg_d[MD-1];
			for (int i = 0; i < cvs_pkg::VECTOR_DIM; i++) begin
				prod_s1[i] <= PW'(mag_d[MD-1][i]) * PW'(scale_eff);
			end
			for (int i = 0; i < cvs_pkg::VECTOR_DIM; i++) begin
				// negative: round magnitude up so the signed result floors
				t = neg_s1[i] ? ((PW+1)'(prod_s1[i]) + (PW+1)'((1 << FRAC_BITS) - 1))
					: (PW+1)'(prod_s1[i]);
				r = (DW+1)'(t >> FRAC_BITS);
				res_s2[i] <= neg_s1[i] ? DW'(~r + 1'b1) : r[DW-1:0];
			end
		end
	end

	assign m_tdata = res_s2;

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: capsule squash activation check
// streams capsule vectors through the block under random idling and stalls
// and compares every squashed vector with a local integer predictor
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import cvs_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int N_RANDOM = 450;

	// expected squashed vectors and the mismatch count
	class squash_scoreboard;
		vec_t squashed_q[$];
		int   n_errors = 0;

		// integer square root, bit by bit
		function automatic logic [63:0] int_sqrt(logic [63:0] v);
			logic [63:0] root;
			logic [63:0] bitv;
			root = 0;
			bitv = 64'd1 << 62;
			while (bitv > v)
				bitv = bitv >> 2;
			while (bitv != 0) begin
				if (v >= root + bitv) begin
					v = v - (root + bitv);
					root = (root >> 1) + bitv;
				end else begin
					root = root >> 1;
				end
				bitv = bitv >> 2;
			end
			return root;
		endfunction

		// squash one vector: v * n/(1+n) / sqrt(n)
		function automatic vec_t squash(vec_t v);
			logic [63:0] unit;
			logic [63:0] mag [VECTOR_DIM];
			logic [63:0] norm;
			logic [63:0] ratio;
			logic [63:0] root;
			logic [63:0] scale;
			logic [63:0] prod;
			logic [63:0] r;
			vec_t res;
			unit = 64'd1 << FRAC;
			norm = 0;
			scale = 0;
			for (int i = 0; i < VECTOR_DIM; i++) begin
				mag[i] = v[i][31] ? (64'd1 << 32) - {32'd0, v[i]} : {32'd0, v[i]};
				norm = norm + ((mag[i] * mag[i]) >> FRAC);
			end
			// saturate instead of wrap
			if (norm > 64'h7FFF_FFFF)
				norm = 64'h7FFF_FFFF;
			if (norm != 0) begin
				ratio = (norm << FRAC) / (norm + unit);
				root = int_sqrt(norm << FRAC);
				if (root != 0)
					scale = (ratio << FRAC) / root;
			end
			for (int i = 0; i < VECTOR_DIM; i++) begin
				prod = mag[i] * scale;
				// floor for negative elements
				if (v[i][31])
					r = 64'd0 - ((prod + unit - 1) >> FRAC);
				else
					r = prod >> FRAC;
				res[i] = r[31:0];
			end
			return res;
		endfunction

		function void note_input(vec_t v);
			squashed_q.push_back(squash(v));
		endfunction

		task check_result(vec_t got);
			vec_t want;
			if (squashed_q.size() == 0) begin
				report_error($sformatf("unexpected result %h", got));
				return;
			end
			want = squashed_q.pop_front();
			for (int i = 0; i < VECTOR_DIM; i++)
				if (got[i] !== want[i])
					report_error($sformatf("squashed_%0d got %h want %h", i, got[i], want[i]));
		endtask

		task report_error(string msg);
			$display("mismatch: %s", msg);
			n_errors++;
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [255:0] s_tdata;   // comp_0 .. comp_7, 32 bits each from bit 0
	logic         m_tvalid;
	logic         m_tready;
	logic [255:0] m_tdata;   // squashed_0 .. squashed_7, 32 bits each from bit 0

	squash_scoreboard board;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	capsule_vector_squash #(.FRAC_BITS(FRAC)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// input transactions are noted, output transactions checked, at the edge
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			board.note_input(vec_t'(s_tdata));
		if (arst_n && m_tvalid && m_tready)
			board.check_result(vec_t'(m_tdata));
	end

	// receiver stalls at the current rate
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// drive one vector, with a random idle gap first, and hold until accepted
	task automatic send_vector(vec_t v);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// random element: mostly small values, sometimes full range
	function automatic logic [31:0] rand_comp(int kind);
		case (kind)
			0: return $urandom;
			1: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
			2: return $urandom_range(0, 32'h3FF) - 32'h200;
			default: return $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
		endcase
	endfunction

	task automatic send_directed();
		vec_t v;
		v = '0;
		send_vector(v);                             // zero norm gives zero vector
		v = '0; v[0] = 32'd1;
		send_vector(v);                             // norm below one lsb
		v = '0; v[3] = 32'h0001_0000;
		send_vector(v);                             // unit vector
		v = '0; v[5] = 32'hFFFF_0000;
		send_vector(v);
		for (int i = 0; i < VECTOR_DIM; i++) v[i] = 32'h7FFF_FFFF;
		send_vector(v);                             // saturated norm
		for (int i = 0; i < VECTOR_DIM; i++) v[i] = 32'h8000_0000;
		send_vector(v);
		for (int i = 0; i < VECTOR_DIM; i++) v[i] = i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		send_vector(v);
		for (int i = 0; i < VECTOR_DIM; i++) v[i] = 32'hFFFF_FFFF;
		send_vector(v);                             // tiny negatives: zero norm gives zero vector
		for (int i = 0; i < VECTOR_DIM; i++) v[i] = 32'h0000_B505;
		send_vector(v);                             // norm of 4.0 in q format
		for (int i = 0; i < VECTOR_DIM; i++) v[i] = 32'h5555_AAAA ^ {32{i[0]}};
		send_vector(v);
		for (int i = 0; i < VECTOR_DIM; i++) v[i] = 32'h0000_8000;
		send_vector(v);
		for (int i = 0; i < VECTOR_DIM; i++) v[i] = 32'hFFFF_8000;
		send_vector(v);
	endtask

	initial begin
		vec_t v;
		int   kind;
		board    = new();
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_directed();
		// idling phases: none, sender idle, receiver stalls, both, then none again
		for (int n = 0; n < N_RANDOM; n++) begin
			case (n * 5 / N_RANDOM)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
				3: begin send_idle_pct = 18; recv_stall_pct = 18; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			kind = $urandom_range(3);
			for (int i = 0; i < VECTOR_DIM; i++)
				v[i] = ($urandom_range(7) == 0) ? 32'd0 : rand_comp(kind);
			send_vector(v);
		end
		s_tvalid <= 1'b0;

		recv_stall_pct = 0;
		while (board.squashed_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (board.n_errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("testbench failed");
		$finish;
	end

endmodule
